### rtl/tlvrb_pkg.sv
`timescale 1ns / 1ps

package tlvrb_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 5;
  localparam int unsigned IDX_W  = 4;
  localparam int unsigned OP_W   = 2;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE   = 2'd0,
    OP_PUBLISH = 2'd1,
    OP_READ    = 2'd2,
    OP_RESET   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    PH_PENDING     = 2'd0,
    PH_TYPE_SENT   = 2'd1,
    PH_LENGTH_SENT = 2'd2,
    PH_IDLE        = 2'd3
  } phase_t;

endpackage

### rtl/tlvrb_if.sv
`timescale 1ns / 1ps

interface tlvrb_in_if;
  logic                            valid;
  logic                            ready;
  logic [tlvrb_pkg::OP_W-1:0]      op;
  logic [tlvrb_pkg::IDX_W-1:0]     byte_index;
  logic [tlvrb_pkg::BYTE_W-1:0]    byte_value;
  logic [tlvrb_pkg::BYTE_W-1:0]    type_code;
  logic [tlvrb_pkg::LEN_W-1:0]     payload_length;

  modport source (
    output valid, op, byte_index, byte_value, type_code, payload_length,
    input  ready
  );
  modport sink (
    input  valid, op, byte_index, byte_value, type_code, payload_length,
    output ready
  );
endinterface

interface tlvrb_out_if;
  logic                            valid;
  logic                            ready;
  logic [tlvrb_pkg::BYTE_W-1:0]    read_byte;
  logic                            accepted;
  logic                            pending;
  logic                            last_byte;

  modport source (
    output valid, read_byte, accepted, pending, last_byte,
    input  ready
  );
  modport sink (
    input  valid, read_byte, accepted, pending, last_byte,
    output ready
  );
endinterface

### rtl/tlvrb_store.sv
`timescale 1ns / 1ps

module tlvrb_store #(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = 4
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [ADDR_W-1:0]            wr_addr,
  input  logic [tlvrb_pkg::BYTE_W-1:0] wr_data,
  input  logic                         rd_en,
  input  logic [ADDR_W-1:0]            rd_addr,
  output logic [tlvrb_pkg::BYTE_W-1:0] rd_data
);

  logic [tlvrb_pkg::BYTE_W-1:0] mem [DEPTH];
  logic [tlvrb_pkg::BYTE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/tlv_readout_buffer_unit.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake      Payload
// in_ch     in   valid/ready    op, byte_index, byte_value, type_code, payload_length
// out_ch    out  valid/ready    read_byte, accepted, pending, last_byte
// cfg       in   cfg_we         cfg_wdata (no-data type code)
//
// State is updated at the accepting edge and the result word is registered there,
// so a word can be accepted on every cycle while the result word is not stalled.
// Payload bytes come from a store with separate write and read ports whose registered
// read data is captured at the same edge as the rest of the result word.
// A word is accepted only when the result register is empty or is being drained.
// rst_n is synchronous; it clears phase, byte counter, no-data code and result valid.

module tlv_readout_buffer_unit #(
  parameter int unsigned STORE_DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  tlvrb_in_if.sink                     in_ch,
  tlvrb_out_if.source                  out_ch,
  input  logic                         cfg_we,
  input  logic [tlvrb_pkg::BYTE_W-1:0] cfg_wdata
);

  localparam int unsigned ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  tlvrb_pkg::phase_t                phase_r, phase_nxt;
  logic [tlvrb_pkg::BYTE_W-1:0]     type_r, type_nxt;
  logic [tlvrb_pkg::LEN_W-1:0]      length_r, length_nxt;
  logic [tlvrb_pkg::LEN_W-1:0]      sent_r, sent_nxt;
  logic [tlvrb_pkg::BYTE_W-1:0]     no_data_r;

  logic                             out_valid_r;
  logic [tlvrb_pkg::BYTE_W-1:0]     byte_r, byte_nxt;
  logic                             use_mem_r, use_mem_nxt;
  logic                             acc_r, acc_nxt;
  logic                             pend_r;
  logic                             last_r, last_nxt;

  logic                             in_take;
  logic                             store_wr;
  logic                             store_rd;
  logic [tlvrb_pkg::BYTE_W-1:0]     store_data;
  logic                             publish_ok;
  logic                             have_byte;
  logic [tlvrb_pkg::LEN_W:0]        sent_inc;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_take     = in_ch.valid && in_ch.ready;

  assign publish_ok = (phase_r == tlvrb_pkg::PH_IDLE) &&
                      (32'(in_ch.payload_length) <= STORE_DEPTH);
  assign have_byte  = (sent_r < length_r) && (32'(sent_r) < STORE_DEPTH);
  assign sent_inc   = {1'b0, sent_r} + {{tlvrb_pkg::LEN_W{1'b0}}, 1'b1};

  assign store_wr = in_take && (in_ch.op == tlvrb_pkg::OP_WRITE) &&
                    (32'(in_ch.byte_index) < STORE_DEPTH);
  assign store_rd = in_take && (in_ch.op == tlvrb_pkg::OP_READ) &&
                    (phase_r == tlvrb_pkg::PH_LENGTH_SENT) && have_byte;

  tlvrb_store #(
    .DEPTH  (STORE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (store_wr),
    .wr_addr (ADDR_W'(in_ch.byte_index)),
    .wr_data (in_ch.byte_value),
    .rd_en   (store_rd),
    .rd_addr (ADDR_W'(sent_r)),
    .rd_data (store_data)
  );

  // Phase sequencing.
  always_comb begin
    phase_nxt = phase_r;
    unique case (in_ch.op)
      tlvrb_pkg::OP_WRITE: begin
        phase_nxt = phase_r;
      end
      tlvrb_pkg::OP_PUBLISH: begin
        if (publish_ok) begin
          phase_nxt = tlvrb_pkg::PH_PENDING;
        end
      end
      tlvrb_pkg::OP_READ: begin
        unique case (phase_r)
          tlvrb_pkg::PH_PENDING:   phase_nxt = tlvrb_pkg::PH_TYPE_SENT;
          tlvrb_pkg::PH_TYPE_SENT: phase_nxt = tlvrb_pkg::PH_LENGTH_SENT;
          tlvrb_pkg::PH_LENGTH_SENT: begin
            if (!have_byte || (sent_inc >= {1'b0, length_r})) begin
              phase_nxt = tlvrb_pkg::PH_IDLE;
            end
          end
          tlvrb_pkg::PH_IDLE:      phase_nxt = tlvrb_pkg::PH_IDLE;
          default:                 phase_nxt = tlvrb_pkg::PH_IDLE;
        endcase
      end
      tlvrb_pkg::OP_RESET: begin
        if (phase_r != tlvrb_pkg::PH_PENDING) begin
          phase_nxt = tlvrb_pkg::PH_IDLE;
        end
      end
      default: phase_nxt = phase_r;
    endcase
  end

  // Record registers and result word.
  always_comb begin
    type_nxt    = type_r;
    length_nxt  = length_r;
    sent_nxt    = sent_r;
    byte_nxt    = '0;
    use_mem_nxt = 1'b0;
    acc_nxt     = 1'b0;
    last_nxt    = 1'b0;
    unique case (in_ch.op)
      tlvrb_pkg::OP_WRITE: begin
        byte_nxt = '0;
      end
      tlvrb_pkg::OP_PUBLISH: begin
        if (publish_ok) begin
          type_nxt   = in_ch.type_code;
          length_nxt = in_ch.payload_length;
          sent_nxt   = '0;
          acc_nxt    = 1'b1;
        end
      end
      tlvrb_pkg::OP_READ: begin
        unique case (phase_r)
          tlvrb_pkg::PH_PENDING:   byte_nxt = type_r;
          tlvrb_pkg::PH_TYPE_SENT: byte_nxt = tlvrb_pkg::BYTE_W'(length_r);
          tlvrb_pkg::PH_LENGTH_SENT: begin
            if (have_byte) begin
              use_mem_nxt = 1'b1;
              sent_nxt    = sent_inc[tlvrb_pkg::LEN_W-1:0];
            end else begin
              byte_nxt = no_data_r;
            end
            if (!have_byte || (sent_inc >= {1'b0, length_r})) begin
              sent_nxt = '0;
              last_nxt = 1'b1;
            end
          end
          tlvrb_pkg::PH_IDLE:      byte_nxt = no_data_r;
          default:                 byte_nxt = no_data_r;
        endcase
      end
      tlvrb_pkg::OP_RESET: begin
        if (phase_r != tlvrb_pkg::PH_PENDING) begin
          sent_nxt = '0;
        end
      end
      default: byte_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= tlvrb_pkg::PH_IDLE;
      sent_r      <= '0;
      no_data_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        no_data_r <= cfg_wdata;
      end
      if (in_take) begin
        phase_r <= phase_nxt;
        sent_r  <= sent_nxt;
      end
      if (in_ch.ready) begin
        out_valid_r <= in_ch.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      type_r    <= type_nxt;
      length_r  <= length_nxt;
      byte_r    <= byte_nxt;
      use_mem_r <= use_mem_nxt;
      acc_r     <= acc_nxt;
      pend_r    <= (phase_nxt == tlvrb_pkg::PH_PENDING);
      last_r    <= last_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.read_byte = use_mem_r ? store_data : byte_r;
  assign out_ch.accepted  = acc_r;
  assign out_ch.pending   = pend_r;
  assign out_ch.last_byte = last_r;

endmodule

### rtl/tlvrb_checker.sv
`timescale 1ns / 1ps

module tlvrb_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [tlvrb_pkg::BYTE_W-1:0] out_read_byte,
  input logic                         out_accepted,
  input logic                         out_pending,
  input logic                         out_last_byte
);

  // A stalled result word keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_byte) &&
      $stable(out_accepted) && $stable(out_pending) && $stable(out_last_byte))
    else $error("stalled result word changed");

  // No new word is taken while the result register is full and stalled.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted over a stalled result");

  // A taken publish always leaves a record waiting.
  a_acc_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_accepted |-> out_pending && !out_last_byte)
    else $error("accepted publish without pending record");

  // Finishing a record leaves nothing waiting.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_byte |-> !out_pending)
    else $error("last byte reported with a record still pending");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind tlv_readout_buffer_unit tlvrb_checker u_tlvrb_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_read_byte (out_ch.read_byte),
  .out_accepted  (out_ch.accepted),
  .out_pending   (out_ch.pending),
  .out_last_byte (out_ch.last_byte)
);
